// ===== sv/ahc_pkg.sv =====
// Shared types and constants for the average hash compare block.
package ahc_pkg;

   localparam int PIXELS  = 64;
   localparam int PIXEL_W = 8;
   localparam int QUANT_W = 6;
   localparam int SUM_W   = 14;
   localparam int AVG_W   = 8;
   localparam int POS_W   = 6;
   localparam int COUNT_W = 7;
   localparam int LIMIT_W = 7;
   localparam int CSR_W   = 7;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SIMILAR_LIMIT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFFERENT_LIMIT = 1'd1;

   localparam logic [LIMIT_W-1:0] SIMILAR_LIMIT_RESET   = 7'd5;
   localparam logic [LIMIT_W-1:0] DIFFERENT_LIMIT_RESET = 7'd10;

   typedef enum logic [1:0] {
      VERDICT_SIMILAR   = 2'd0,
      VERDICT_SOMEWHAT  = 2'd1,
      VERDICT_DIFFERENT = 2'd2
   } verdict_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic               en;
      logic [QUANT_W-1:0] first;
      logic [QUANT_W-1:0] second;
   } lane_write_type;

   typedef struct packed {
      logic clear;
      logic accumulate;
   } merge_ctrl_type;

endpackage

// ===== sv/ahc_lane.sv =====
// One lane: pixel store for its share of positions and the hash bit compare.
module ahc_lane #(
   parameter int ADDR_W = 3
) (
   input  logic                         clock,
   input  ahc_pkg::lane_write_type      wr,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [ADDR_W-1:0]            rd_addr,
   input  logic [ahc_pkg::AVG_W-1:0]    avg_first,
   input  logic [ahc_pkg::AVG_W-1:0]    avg_second,
   output logic                         differ
);
   import ahc_pkg::*;

   localparam int DEPTH = 1 << ADDR_W;

   logic [QUANT_W-1:0] mem_first  [DEPTH];
   logic [QUANT_W-1:0] mem_second [DEPTH];
   logic [QUANT_W-1:0] rd_first_ff;
   logic [QUANT_W-1:0] rd_second_ff;
   logic               hash_first;
   logic               hash_second;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_first[wr_addr]  <= wr.first;
         mem_second[wr_addr] <= wr.second;
      end
      rd_first_ff  <= mem_first[rd_addr];
      rd_second_ff <= mem_second[rd_addr];
   end

   always_comb begin
      hash_first  = {rd_first_ff, 2'b00} >= avg_first;
      hash_second = {rd_second_ff, 2'b00} >= avg_second;
      differ      = hash_first ^ hash_second;
   end

endmodule

// ===== sv/ahc_merge.sv =====
// Merging stage: counts differing lanes and accumulates over the scan.
module ahc_merge #(
   parameter int LANES = 8
) (
   input  logic                          clock,
   input  ahc_pkg::merge_ctrl_type       ctrl,
   input  logic [LANES-1:0]              differ,
   output logic [ahc_pkg::COUNT_W-1:0]   count
);
   import ahc_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.accumulate) begin
         count_in = count_ff + COUNT_W'($countones(differ));
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
   end

   assign count = count_ff;

endmodule

// ===== sv/average_hash_compare.sv =====
// Top level of the 8x8 average hash compare block.
// Takes one pixel pair per cycle while busy is low; the 64th pair of a frame
// starts a scan of the lane stores, one row of LANES positions per cycle, and
// busy stays high through the scan state and the drain state after it. The
// result strobe rsp_valid rises in the report state that follows them. The
// scan walks the stores row by row, as each lane store has a single read port.
// The result is shown for one cycle only and must be captured then; a new pair
// may be taken in that cycle.
module average_hash_compare #(
   parameter int LANES = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_start,
   output logic                           busy,
   input  logic [ahc_pkg::PIXEL_W-1:0]    req_pixel_first,
   input  logic [ahc_pkg::PIXEL_W-1:0]    req_pixel_second,
   output logic                           rsp_valid,
   output logic [ahc_pkg::COUNT_W-1:0]    rsp_diff_count,
   output logic [1:0]                     rsp_verdict,
   input  logic                           csr_wr_en,
   input  logic [ahc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ahc_pkg::CSR_W-1:0]      csr_data
);
   import ahc_pkg::*;

   localparam int LANE_W = $clog2(LANES);
   localparam int DEPTH  = PIXELS / LANES;
   localparam int ADDR_W = $clog2(DEPTH);

   state_type          state_ff;
   state_type          state_in;
   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   pos_in;
   logic [ADDR_W-1:0]  scan_ff;
   logic [ADDR_W-1:0]  scan_in;
   logic               rd_valid_ff;
   logic [SUM_W-1:0]   sum_first_ff;
   logic [SUM_W-1:0]   sum_first_in;
   logic [SUM_W-1:0]   sum_second_ff;
   logic [SUM_W-1:0]   sum_second_in;
   logic [AVG_W-1:0]   avg_first_ff;
   logic [AVG_W-1:0]   avg_second_ff;
   logic [LIMIT_W-1:0] similar_limit_ff;
   logic [LIMIT_W-1:0] different_limit_ff;

   logic               accept;
   logic               last_pixel;
   logic [QUANT_W-1:0] quant_first;
   logic [QUANT_W-1:0] quant_second;
   logic [LANES-1:0]   differ;
   logic [COUNT_W-1:0] count;
   merge_ctrl_type     merge_ctrl;
   verdict_type        verdict;

   assign accept       = req_start && !busy;
   assign last_pixel   = pos_ff == POS_W'(PIXELS - 1);
   assign quant_first  = req_pixel_first[PIXEL_W-1:2];
   assign quant_second = req_pixel_second[PIXEL_W-1:2];

   always_comb begin
      state_in  = state_ff;
      scan_in   = scan_ff;
      busy      = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            scan_in = '0;
            if (accept && last_pixel) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            busy    = 1'b1;
            scan_in = scan_ff + 1'b1;
            if (scan_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            busy     = 1'b1;
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            rsp_valid = 1'b1;
            scan_in   = '0;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pos_in        = pos_ff;
      sum_first_in  = sum_first_ff;
      sum_second_in = sum_second_ff;
      if (accept) begin
         pos_in        = pos_ff + 1'b1;
         sum_first_in  = sum_first_ff + SUM_W'({quant_first, 2'b00});
         sum_second_in = sum_second_ff + SUM_W'({quant_second, 2'b00});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         pos_ff             <= '0;
         scan_ff            <= '0;
         rd_valid_ff        <= 1'b0;
         sum_first_ff       <= '0;
         sum_second_ff      <= '0;
         similar_limit_ff   <= SIMILAR_LIMIT_RESET;
         different_limit_ff <= DIFFERENT_LIMIT_RESET;
      end else begin
         state_ff    <= state_in;
         pos_ff      <= pos_in;
         scan_ff     <= scan_in;
         rd_valid_ff <= state_ff == ST_SCAN;
         if (accept && last_pixel) begin
            sum_first_ff  <= '0;
            sum_second_ff <= '0;
         end else begin
            sum_first_ff  <= sum_first_in;
            sum_second_ff <= sum_second_in;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SIMILAR_LIMIT:   similar_limit_ff   <= csr_data[LIMIT_W-1:0];
               CSR_DIFFERENT_LIMIT: different_limit_ff <= csr_data[LIMIT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && last_pixel) begin
         avg_first_ff  <= sum_first_in[SUM_W-1 -: AVG_W];
         avg_second_ff <= sum_second_in[SUM_W-1 -: AVG_W];
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      lane_write_type lane_wr;

      always_comb begin
         lane_wr.en     = accept && (pos_ff[LANE_W-1:0] == LANE_W'(i));
         lane_wr.first  = quant_first;
         lane_wr.second = quant_second;
      end

      ahc_lane #(
         .ADDR_W (ADDR_W)
      ) u_lane (
         .clock      (clock),
         .wr         (lane_wr),
         .wr_addr    (pos_ff[POS_W-1 -: ADDR_W]),
         .rd_addr    (scan_ff),
         .avg_first  (avg_first_ff),
         .avg_second (avg_second_ff),
         .differ     (differ[i])
      );
   end

   always_comb begin
      merge_ctrl.clear      = accept && last_pixel;
      merge_ctrl.accumulate = rd_valid_ff;
   end

   ahc_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock  (clock),
      .ctrl   (merge_ctrl),
      .differ (differ),
      .count  (count)
   );

   always_comb begin
      if (count <= similar_limit_ff) begin
         verdict = VERDICT_SIMILAR;
      end else if (count > different_limit_ff) begin
         verdict = VERDICT_DIFFERENT;
      end else begin
         verdict = VERDICT_SOMEWHAT;
      end
   end

   assign rsp_diff_count = count;
   assign rsp_verdict    = verdict;

endmodule

// ===== sv/ahc_checker.sv =====
// Port-level checks for the average hash compare block, with its bind.
module ahc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [ahc_pkg::COUNT_W-1:0]   rsp_diff_count,
   input logic [1:0]                    rsp_verdict
);
   import ahc_pkg::*;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_diff_count <= COUNT_W'(PIXELS))
      else $error("difference count above pixel count");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict == VERDICT_SIMILAR || rsp_verdict == VERDICT_SOMEWHAT
                     || rsp_verdict == VERDICT_DIFFERENT))
      else $error("verdict code out of range");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a preceding scan");

   a_busy_after_transaction: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(req_start))
      else $error("scan started without a transaction");

endmodule

bind average_hash_compare ahc_checker u_ahc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_start      (req_start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_diff_count (rsp_diff_count),
   .rsp_verdict    (rsp_verdict)
);

// ===== tb/tb_average_hash_compare.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for average_hash_compare: pixel frames in, hash distances predicted.
module tb_average_hash_compare;
   import ahc_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 16;

   typedef struct packed {
      logic [PIXEL_W-1:0] first;
      logic [PIXEL_W-1:0] second;
   } pixel_pair_type;

   typedef struct {
      logic [COUNT_W-1:0] diff_count;
      verdict_type        verdict;
   } score_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_start = 1'b0;
   logic                  busy;
   logic [PIXEL_W-1:0]    req_pixel_first = '0;
   logic [PIXEL_W-1:0]    req_pixel_second = '0;
   logic                  rsp_valid;
   logic [COUNT_W-1:0]    rsp_diff_count;
   logic [1:0]            rsp_verdict;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_SIMILAR_LIMIT;
   logic [CSR_W-1:0]      csr_data = '0;

   pixel_pair_type    pending_pairs[$];
   score_type         expected_scores[$];
   int                pairs_queued = 0;
   int                pairs_taken = 0;
   int                mismatches = 0;
   int                cycle_count = 0;
   int                gap_pct = 0;
   int                calm_left = 0;
   logic              took_pair = 1'b0;

   logic [QUANT_W-1:0] thumb_a[PIXELS];
   logic [QUANT_W-1:0] thumb_b[PIXELS];
   logic [SUM_W-1:0]   total_a = '0;
   logic [SUM_W-1:0]   total_b = '0;
   logic [POS_W-1:0]   next_pos = '0;
   logic [LIMIT_W-1:0] similar_lim = SIMILAR_LIMIT_RESET;
   logic [LIMIT_W-1:0] different_lim = DIFFERENT_LIMIT_RESET;

   logic [PIXEL_W-1:0] frame_a[PIXELS];
   logic [PIXEL_W-1:0] frame_b[PIXELS];

   average_hash_compare i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_start        (req_start),
      .busy             (busy),
      .req_pixel_first  (req_pixel_first),
      .req_pixel_second (req_pixel_second),
      .rsp_valid        (rsp_valid),
      .rsp_diff_count   (rsp_diff_count),
      .rsp_verdict      (rsp_verdict),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [COUNT_W-1:0] hash_mismatch_count();
      logic [AVG_W-1:0]   mean_a;
      logic [AVG_W-1:0]   mean_b;
      logic [COUNT_W-1:0] n;
      logic               bit_a;
      logic               bit_b;
      n = '0;
      mean_a = AVG_W'(total_a / PIXELS);
      mean_b = AVG_W'(total_b / PIXELS);
      for (int i = 0; i < PIXELS; i++) begin
         bit_a = {thumb_a[i], 2'b00} >= mean_a;
         bit_b = {thumb_b[i], 2'b00} >= mean_b;
         if (bit_a != bit_b) n++;
      end
      return n;
   endfunction

   function automatic verdict_type grade_distance(input logic [COUNT_W-1:0] d);
      if (d <= similar_lim) return VERDICT_SIMILAR;
      else if (d > different_lim) return VERDICT_DIFFERENT;
      else return VERDICT_SOMEWHAT;
   endfunction

   task automatic absorb_pixel_pair(input logic [PIXEL_W-1:0] pa, input logic [PIXEL_W-1:0] pb);
      score_type s;
      thumb_a[next_pos] = pa[PIXEL_W-1:2];
      thumb_b[next_pos] = pb[PIXEL_W-1:2];
      total_a = total_a + SUM_W'({pa[PIXEL_W-1:2], 2'b00});
      total_b = total_b + SUM_W'({pb[PIXEL_W-1:2], 2'b00});
      if (next_pos == POS_W'(PIXELS - 1)) begin
         s.diff_count = hash_mismatch_count();
         s.verdict = grade_distance(s.diff_count);
         expected_scores.insert(expected_scores.size(), s);
         total_a = '0;
         total_b = '0;
      end
      next_pos = next_pos + 1'b1;
   endtask

   task automatic push_frame();
      pixel_pair_type p;
      for (int i = 0; i < PIXELS; i++) begin
         p.first = frame_a[i];
         p.second = frame_b[i];
         pending_pairs.insert(pending_pairs.size(), p);
         pairs_queued++;
      end
   endtask

   task automatic push_random_frame();
      int mode;
      int flips;
      int c;
      int v;
      mode = $urandom_range(0, 5);
      flips = $urandom_range(0, 24);
      c = $urandom_range(0, 255);
      for (int i = 0; i < PIXELS; i++) begin
         case (mode)
            0: begin
               frame_a[i] = PIXEL_W'($urandom_range(0, 255));
               frame_b[i] = PIXEL_W'($urandom_range(0, 255));
            end
            3: begin
               frame_a[i] = PIXEL_W'(c);
               v = c + $urandom_range(0, 16) - 8;
               frame_b[i] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : PIXEL_W'(v);
            end
            4: begin
               frame_a[i] = {{6{$urandom_range(0, 1) == 1}}, 2'($urandom_range(0, 3))};
               frame_b[i] = {{6{$urandom_range(0, 1) == 1}}, 2'($urandom_range(0, 3))};
            end
            5: begin
               frame_a[i] = PIXEL_W'($urandom_range(0, 255));
               frame_b[i] = ~frame_a[i];
            end
            default: begin
               frame_a[i] = PIXEL_W'($urandom_range(0, 255));
               frame_b[i] = {frame_a[i][7:2], 2'($urandom_range(0, 3))};
            end
         endcase
      end
      if (mode != 0) begin
         for (int k = 0; k < flips; k++) begin
            v = $urandom_range(0, PIXELS - 1);
            frame_b[v] = ~frame_b[v];
         end
      end
      push_frame();
   endtask

   task automatic write_limit(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic settle();
      wait (pending_pairs.size() == 0 && pairs_taken == pairs_queued
            && expected_scores.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // drive pixel pairs from the pending queue
   always @(negedge clock) begin
      pixel_pair_type p;
      logic           hold_off;
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 99) < 2) calm_left = $urandom_range(20, 80);
      hold_off = (calm_left == 0) && ($urandom_range(0, 99) < gap_pct);
      if (reset) begin
         req_start <= 1'b0;
      end else if (!req_start || took_pair) begin
         if (pending_pairs.size() > 0 && !hold_off) begin
            p = pending_pairs.pop_front();
            req_start <= 1'b1;
            req_pixel_first <= p.first;
            req_pixel_second <= p.second;
         end else begin
            req_start <= 1'b0;
            req_pixel_first <= PIXEL_W'($urandom_range(0, 255));
            req_pixel_second <= PIXEL_W'($urandom_range(0, 255));
         end
      end
   end

   // watch transactions, feed the predictor and check results
   always @(posedge clock) begin
      score_type s;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         took_pair = 1'b0;
         if (!reset) begin
            if (rsp_valid) begin
               if (expected_scores.size() == 0) begin
                  $error("unexpected result: diff_count %0d verdict %0d",
                         rsp_diff_count, rsp_verdict);
                  mismatches++;
               end else begin
                  s = expected_scores.pop_front();
                  if (rsp_diff_count !== s.diff_count) begin
                     $error("diff_count: expected %0d, actual %0d",
                            s.diff_count, rsp_diff_count);
                     mismatches++;
                  end
                  if (rsp_verdict !== s.verdict) begin
                     $error("verdict: expected %0d, actual %0d", s.verdict, rsp_verdict);
                     mismatches++;
                  end
               end
            end
            if (csr_wr_en) begin
               case (csr_index)
                  CSR_SIMILAR_LIMIT:   similar_lim = csr_data;
                  CSR_DIFFERENT_LIMIT: different_lim = csr_data;
                  default: ;
               endcase
            end
            if (req_start && !busy) begin
               took_pair = 1'b1;
               pairs_taken++;
               absorb_pixel_pair(req_pixel_first, req_pixel_second);
            end
         end
      end
   end

   initial begin
      logic [LIMIT_W-1:0] sim_set[12];
      logic [LIMIT_W-1:0] dif_set[12];
      sim_set[0] = 7'd0;   dif_set[0] = 7'd0;
      sim_set[1] = 7'd64;  dif_set[1] = 7'd64;
      sim_set[2] = 7'd127; dif_set[2] = 7'd127;
      sim_set[3] = 7'd0;   dif_set[3] = 7'd64;
      sim_set[4] = 7'd40;  dif_set[4] = 7'd12;
      sim_set[5] = 7'd127; dif_set[5] = 7'd0;
      for (int p = 6; p < 12; p++) begin
         sim_set[p] = LIMIT_W'($urandom_range(0, 30));
         dif_set[p] = LIMIT_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                                         : sim_set[p] + $urandom_range(0, 30));
      end

      gap_pct = 32;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset limits: flat frames, both hashes all ones
      for (int i = 0; i < PIXELS; i++) begin
         frame_a[i] = 8'd0;
         frame_b[i] = 8'd0;
      end
      push_frame();
      for (int i = 0; i < PIXELS; i++) begin
         frame_a[i] = 8'd255;
         frame_b[i] = 8'd0;
      end
      push_frame();
      // checkerboard against its inverse: every position differs
      for (int i = 0; i < PIXELS; i++) begin
         frame_a[i] = ((i / 8 + i) % 2 == 1) ? 8'd255 : 8'd0;
         frame_b[i] = ~frame_a[i];
      end
      push_frame();
      // ramp against the same ramp with the low bits that quantisation drops set, a few inverted
      for (int i = 0; i < PIXELS; i++) begin
         frame_a[i] = PIXEL_W'(i * 4);
         frame_b[i] = (i % 9 == 0) ? PIXEL_W'(255 - i * 4) : PIXEL_W'(i * 4 + 3);
      end
      push_frame();
      settle();

      for (int p = 0; p < 12; p++) begin
         gap_pct = (p < 4) ? 32 : (p < 8) ? 86 : 0;
         write_limit(CSR_SIMILAR_LIMIT, sim_set[p]);
         write_limit(CSR_DIFFERENT_LIMIT, dif_set[p]);
         repeat ((p < 8) ? 2 : 1) push_random_frame();
         settle();
      end

      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/ahc_pkg.sv
sv/ahc_lane.sv
sv/ahc_merge.sv
sv/average_hash_compare.sv
sv/ahc_checker.sv
tb/tb_average_hash_compare.sv
